// ===== rtl/amtq_pkg.sv =====
// Shared constants, stage types and step functions for the matrix decomposition pipeline.
package amtq_pkg;

	// Root and quotient units retire one result bit per stage.
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 62;
	localparam int NUM_W     = 62;
	localparam int DEN_W     = 33;
	localparam int SQ_LAT    = SQ_STEPS;
	localparam int DIV_LAT   = DIV_STEPS;

	// Latency of each section and of the whole block, in cycles.
	localparam int COL_LAT   = 3 + SQ_LAT + DIV_LAT + 1;
	localparam int SHEP_LAT  = 1 + SQ_LAT + DIV_LAT + 1;
	localparam int NORM_LAT  = 5 + SQ_LAT + DIV_LAT + 1;
	localparam int TOTAL_LAT = COL_LAT + SHEP_LAT + NORM_LAT;

	// One in signed Q2.30.
	localparam logic [30:0] Q_ONE = 31'h4000_0000;

	// Shepperd branch codes.
	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	typedef struct packed {
		logic [63:0] v;
		logic [32:0] rem;
		logic [31:0] root;
	} sq_state_t;

	typedef struct packed {
		logic [NUM_W-1:0] n;
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [NUM_W-1:0] quo;
	} div_state_t;

	// One step of the digit-by-digit square root: two radicand bits in, one root bit out.
	function automatic sq_state_t sq_step(input sq_state_t s);
		sq_state_t r;
		logic [34:0] rem2;
		logic [34:0] trial;
		rem2 = {s.rem, s.v[63:62]};
		trial = {1'b0, s.root, 2'b01};
		r.v = {s.v[61:0], 2'b00};
		if (rem2 >= trial) begin
			r.rem = 33'(rem2 - trial);
			r.root = {s.root[30:0], 1'b1};
		end else begin
			r.rem = rem2[32:0];
			r.root = {s.root[30:0], 1'b0};
		end
		return r;
	endfunction

	// One step of restoring division: one numerator bit in, one quotient bit out.
	function automatic div_state_t div_step(input div_state_t s);
		div_state_t r;
		logic [DEN_W:0] rem2;
		rem2 = {s.rem, s.n[NUM_W-1]};
		r.n = {s.n[NUM_W-2:0], 1'b0};
		r.den = s.den;
		if (rem2 >= {1'b0, s.den}) begin
			r.rem = DEN_W'(rem2 - {1'b0, s.den});
			r.quo = {s.quo[NUM_W-2:0], 1'b1};
		end else begin
			r.rem = rem2[DEN_W-1:0];
			r.quo = {s.quo[NUM_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// Position of the highest set bit; zero for a zero word.
	function automatic logic [5:0] msb64(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

endpackage

// ===== rtl/affine_matrix_to_trs_quaternion_unit.sv =====
// Top level: affine matrix to translation, rotation quaternion and scale.
//
// Input channel s_axis: one beat carries the upper 3x4 part of a shear-free
// affine matrix in signed Q16.16. Output channel m_axis: one beat carries the
// translation (passed through), the unit rotation quaternion in signed Q2.30
// and the three column lengths in unsigned Q16.16.
// Every input beat produces exactly one output beat, in order.
// Throughput is one beat per cycle while m_axis_tready does not stall the
// output. An accepted input beat passes through column lengths and
// normalization, the Shepperd stage and the quaternion normalization. The
// square root and divider units retire one bit per stage, which sets the
// pipeline depth.
// The whole pipeline advances together; s_axis_tready is high whenever the
// output register is empty or being taken, so a stalled receiver holds every
// stage in place and nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset. After reset the
// output register is empty, so s_axis_tready is high and a beat can be taken.
module affine_matrix_to_trs_quaternion_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// r00, r10, r20, r01, r11, r21, r02, r12, r22, trans_x, trans_y, trans_z
	input  logic [383:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_tx, out_ty, out_tz, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
	output logic [319:0] m_axis_tdata
);

	localparam int SCL_LAT = amtq_pkg::SHEP_LAT + amtq_pkg::NORM_LAT;

	logic                  en;
	logic                  vld_q [amtq_pkg::TOTAL_LAT];
	logic [2:0][31:0]      len;
	logic [2:0][2:0][31:0] nc;
	logic [3:0][61:0]      qmag;
	logic [3:0]            qneg;
	logic [3:0][31:0]      quat;
	logic [95:0]           trn_q [amtq_pkg::TOTAL_LAT];
	logic [95:0]           scl_q [SCL_LAT];

	// Global advance: the output register is empty or its beat is taken.
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < amtq_pkg::TOTAL_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= s_axis_tvalid;
			for (int i = 1; i < amtq_pkg::TOTAL_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign m_axis_tvalid = vld_q[amtq_pkg::TOTAL_LAT-1];

	// Column lengths and normalized columns.
	for (genvar j = 0; j < 3; j++) begin : g_col
		amtq_column u_col (
			.clk (clk),
			.en  (en),
			.m   (s_axis_tdata[j*96 +: 96]),
			.len (len[j]),
			.nrm (nc[j])
		);
	end

	amtq_shepperd u_shep (.clk(clk), .en(en), .nc(nc), .qmag(qmag), .qneg(qneg));

	amtq_qnorm u_qnorm (.clk(clk), .en(en), .qmag(qmag), .qneg(qneg), .quat(quat));

	// Translation and scale ride along to the output.
	always_ff @(posedge clk) begin
		if (en) begin
			trn_q[0] <= s_axis_tdata[383:288];
			for (int i = 1; i < amtq_pkg::TOTAL_LAT; i++) begin
				trn_q[i] <= trn_q[i-1];
			end
			scl_q[0] <= len;
			for (int i = 1; i < SCL_LAT; i++) begin
				scl_q[i] <= scl_q[i-1];
			end
		end
	end

	assign m_axis_tdata = {scl_q[SCL_LAT-1], quat, trn_q[amtq_pkg::TOTAL_LAT-1]};

endmodule

// ===== rtl/amtq_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module amtq_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	amtq_pkg::sq_state_t st_q [amtq_pkg::SQ_STEPS];
	amtq_pkg::sq_state_t init;

	assign init = '{v: rad, rem: '0, root: '0};

	// Each stage resolves one bit of the root.
	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= amtq_pkg::sq_step(init);
			for (int i = 1; i < amtq_pkg::SQ_STEPS; i++) begin
				st_q[i] <= amtq_pkg::sq_step(st_q[i-1]);
			end
		end
	end

	assign root = st_q[amtq_pkg::SQ_STEPS-1].root;

endmodule

// ===== rtl/amtq_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module amtq_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic [amtq_pkg::NUM_W-1:0]     num,
	input  logic [amtq_pkg::DEN_W-1:0]     den,
	output logic [amtq_pkg::NUM_W-1:0]     quo
);

	amtq_pkg::div_state_t st_q [amtq_pkg::DIV_STEPS];
	amtq_pkg::div_state_t init;

	assign init = '{n: num, rem: '0, den: den, quo: '0};

	// Each stage resolves one bit of the quotient.
	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= amtq_pkg::div_step(init);
			for (int i = 1; i < amtq_pkg::DIV_STEPS; i++) begin
				st_q[i] <= amtq_pkg::div_step(st_q[i-1]);
			end
		end
	end

	assign quo = st_q[amtq_pkg::DIV_STEPS-1].quo;

endmodule

// ===== rtl/amtq_column.sv =====
// Column length and normalized column elements for one basis column.
module amtq_column (
	input  logic             clk,
	input  logic             en,
	input  logic [2:0][31:0] m,
	output logic [31:0]      len,
	output logic [2:0][31:0] nrm
);

	typedef struct packed {
		logic [2:0][31:0] a;
		logic [2:0]       neg;
		logic [4:0]       k;
		logic             zero;
	} col_tag_t;

	typedef struct packed {
		logic [31:0] len;
		logic [2:0]  neg;
	} col_out_t;

	logic [2:0][31:0] mag_c;
	logic [2:0][31:0] a_s1, a_s2;
	logic [2:0]       neg_s1, neg_s2;
	logic [2:0][63:0] sq_s1;
	logic [63:0]      sum_s2, sum_s3, sh_s3;
	col_tag_t         tag_s3;
	logic [5:0]       p_c;
	logic [4:0]       k_c;
	logic [6:0]       kd_c;
	col_tag_t         tag_d [amtq_pkg::SQ_LAT];
	col_tag_t         tag_a;
	logic [31:0]      len_root, l_root;
	logic [2:0][61:0] num_c, quo;
	logic [2:0][61:0] ak_c;
	logic [32:0]      den_c;
	col_out_t         out_d [amtq_pkg::DIV_LAT];
	col_out_t         out_a;
	logic [2:0][31:0] nrm_s4;
	logic [31:0]      len_s4;

	// Magnitudes and their squares.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = m[i][31] ? 32'(-m[i]) : m[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= mag_c;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= m[i][31];
				sq_s1[i] <= mag_c[i] * mag_c[i];
			end
		end
	end

	// Sum of squares; three squares of at most 2^62 each cannot overflow 64 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			a_s2 <= a_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Block scaling: shift the sum up by an even count until it reaches 2^60.
	always_comb begin
		p_c = amtq_pkg::msb64(sum_s2);
		kd_c = (7'd61 - {1'b0, p_c}) >> 1;
		k_c = (p_c >= 6'd60) ? 5'd0 : kd_c[4:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum_s2;
			sh_s3 <= sum_s2 << {k_c, 1'b0};
			tag_s3 <= '{a: a_s2, neg: neg_s2, k: k_c, zero: (sum_s2 == 64'd0)};
		end
	end

	amtq_sqrt u_len (.clk(clk), .en(en), .rad(sum_s3), .root(len_root));
	amtq_sqrt u_lsc (.clk(clk), .en(en), .rad(sh_s3), .root(l_root));

	// Side data follows the root units.
	always_ff @(posedge clk) begin
		if (en) begin
			tag_d[0] <= tag_s3;
			for (int i = 1; i < amtq_pkg::SQ_LAT; i++) begin
				tag_d[i] <= tag_d[i-1];
			end
		end
	end

	assign tag_a = tag_d[amtq_pkg::SQ_LAT-1];

	// Scaled element over the scaled length, in Q30.
	always_comb begin
		den_c = tag_a.zero ? 33'd1 : {1'b0, l_root};
		for (int i = 0; i < 3; i++) begin
			ak_c[i] = {30'b0, tag_a.a[i]} << tag_a.k;
			num_c[i] = {ak_c[i][31:0], 30'b0};
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		amtq_div u_div (.clk(clk), .en(en), .num(num_c[g]), .den(den_c), .quo(quo[g]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d[0] <= '{len: len_root, neg: tag_a.neg};
			for (int i = 1; i < amtq_pkg::DIV_LAT; i++) begin
				out_d[i] <= out_d[i-1];
			end
		end
	end

	assign out_a = out_d[amtq_pkg::DIV_LAT-1];

	// Clamp to one and restore the sign.
	always_ff @(posedge clk) begin
		if (en) begin
			len_s4 <= out_a.len;
			for (int i = 0; i < 3; i++) begin
				if (quo[i] > {31'b0, amtq_pkg::Q_ONE}) begin
					nrm_s4[i] <= out_a.neg[i] ? 32'(-{1'b0, amtq_pkg::Q_ONE})
						: {1'b0, amtq_pkg::Q_ONE};
				end else begin
					nrm_s4[i] <= out_a.neg[i] ? 32'(-{1'b0, quo[i][30:0]})
						: {1'b0, quo[i][30:0]};
				end
			end
		end
	end

	assign len = len_s4;
	assign nrm = nrm_s4;

endmodule

// ===== rtl/amtq_shepperd.sv =====
// Shepperd four-branch quaternion from the normalized rotation block.
module amtq_shepperd (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2:0][2:0][31:0] nc,
	output logic [3:0][61:0]      qmag,
	output logic [3:0]            qneg
);

	typedef struct packed {
		logic [1:0]       br;
		logic [2:0][31:0] nmag;
		logic [2:0]       nneg;
	} shp_tag_t;

	typedef struct packed {
		logic [1:0]  br;
		logic [2:0]  nneg;
		logic [30:0] main;
	} shp_out_t;

	logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [33:0] tr_c;
	logic signed [34:0] v_c;
	logic signed [32:0] ex_c, ey_c, ez_c, pxy_c, pxz_c, pyz_c;
	logic signed [32:0] n_c [3];
	logic [32:0]        nm_c [3];
	logic [1:0]         br_c;
	logic [1:0]         br_s1;
	logic [32:0]        v_s1;
	logic [2:0][31:0]   nmag_s1;
	logic [2:0]         nneg_s1;
	logic [31:0]        sq;
	shp_tag_t           tag_d [amtq_pkg::SQ_LAT];
	shp_tag_t           tag_a;
	logic [32:0]        s_c, den_c;
	logic [2:0][61:0]   num_c, quo;
	shp_out_t           out_d [amtq_pkg::DIV_LAT];
	shp_out_t           out_a;
	logic [61:0]        main_c;
	logic [3:0][61:0]   qmag_s4;
	logic [3:0]         qneg_s4;

	assign r00 = nc[0][0];
	assign r10 = nc[0][1];
	assign r20 = nc[0][2];
	assign r01 = nc[1][0];
	assign r11 = nc[1][1];
	assign r21 = nc[1][2];
	assign r02 = nc[2][0];
	assign r12 = nc[2][1];
	assign r22 = nc[2][2];

	// Branch choice, radicand and the three off-axis numerators.
	always_comb begin
		tr_c = 34'(r00) + 34'(r11) + 34'(r22);
		ex_c = 33'(r21) - 33'(r12);
		ey_c = 33'(r02) - 33'(r20);
		ez_c = 33'(r10) - 33'(r01);
		pxy_c = 33'(r01) + 33'(r10);
		pxz_c = 33'(r02) + 33'(r20);
		pyz_c = 33'(r12) + 33'(r21);
		if (tr_c > 34'sd0) begin
			br_c = amtq_pkg::BR_TRACE;
			v_c = 35'(tr_c) + 35'sd1073741824;
			n_c[0] = ex_c;
			n_c[1] = ey_c;
			n_c[2] = ez_c;
		end else if (r00 > r11 && r00 > r22) begin
			br_c = amtq_pkg::BR_X;
			v_c = 35'sd1073741824 + 35'(r00) - 35'(r11) - 35'(r22);
			n_c[0] = ex_c;
			n_c[1] = pxy_c;
			n_c[2] = pxz_c;
		end else if (r11 > r22) begin
			br_c = amtq_pkg::BR_Y;
			v_c = 35'sd1073741824 + 35'(r11) - 35'(r00) - 35'(r22);
			n_c[0] = ey_c;
			n_c[1] = pxy_c;
			n_c[2] = pyz_c;
		end else begin
			br_c = amtq_pkg::BR_Z;
			v_c = 35'sd1073741824 + 35'(r22) - 35'(r00) - 35'(r11);
			n_c[0] = ez_c;
			n_c[1] = pxz_c;
			n_c[2] = pyz_c;
		end
		for (int i = 0; i < 3; i++) begin
			nm_c[i] = n_c[i][32] ? 33'(-n_c[i]) : n_c[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			br_s1 <= br_c;
			v_s1 <= (v_c <= 35'sd0) ? 33'd0 : v_c[32:0];
			for (int i = 0; i < 3; i++) begin
				nmag_s1[i] <= nm_c[i][31:0];
				nneg_s1[i] <= n_c[i][32];
			end
		end
	end

	amtq_sqrt u_sqrt (.clk(clk), .en(en), .rad({1'b0, v_s1, 30'b0}), .root(sq));

	always_ff @(posedge clk) begin
		if (en) begin
			tag_d[0] <= '{br: br_s1, nmag: nmag_s1, nneg: nneg_s1};
			for (int i = 1; i < amtq_pkg::SQ_LAT; i++) begin
				tag_d[i] <= tag_d[i-1];
			end
		end
	end

	assign tag_a = tag_d[amtq_pkg::SQ_LAT-1];

	// Divide each numerator by twice the root.
	always_comb begin
		s_c = {sq, 1'b0};
		den_c = (s_c == 33'd0) ? 33'd1 : s_c;
		for (int i = 0; i < 3; i++) begin
			num_c[i] = {tag_a.nmag[i], 30'b0};
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		amtq_div u_div (.clk(clk), .en(en), .num(num_c[g]), .den(den_c), .quo(quo[g]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d[0] <= '{br: tag_a.br, nneg: tag_a.nneg, main: sq[31:1]};
			for (int i = 1; i < amtq_pkg::DIV_LAT; i++) begin
				out_d[i] <= out_d[i-1];
			end
		end
	end

	assign out_a = out_d[amtq_pkg::DIV_LAT-1];
	assign main_c = {31'b0, out_a.main};

	// Place the components in x, y, z, w order for the branch taken.
	always_ff @(posedge clk) begin
		if (en) begin
			case (out_a.br)
				amtq_pkg::BR_TRACE: begin
					qmag_s4 <= {main_c, quo[2], quo[1], quo[0]};
					qneg_s4 <= {1'b0, out_a.nneg[2], out_a.nneg[1], out_a.nneg[0]};
				end
				amtq_pkg::BR_X: begin
					qmag_s4 <= {quo[0], quo[2], quo[1], main_c};
					qneg_s4 <= {out_a.nneg[0], out_a.nneg[2], out_a.nneg[1], 1'b0};
				end
				amtq_pkg::BR_Y: begin
					qmag_s4 <= {quo[0], quo[2], main_c, quo[1]};
					qneg_s4 <= {out_a.nneg[0], out_a.nneg[2], 1'b0, out_a.nneg[1]};
				end
				default: begin
					qmag_s4 <= {quo[0], main_c, quo[2], quo[1]};
					qneg_s4 <= {out_a.nneg[0], 1'b0, out_a.nneg[2], out_a.nneg[1]};
				end
			endcase
		end
	end

	assign qmag = qmag_s4;
	assign qneg = qneg_s4;

endmodule

// ===== rtl/amtq_qnorm.sv =====
// Quaternion normalization to signed Q2.30 with the identity for a zero quaternion.
module amtq_qnorm (
	input  logic             clk,
	input  logic             en,
	input  logic [3:0][61:0] qmag,
	input  logic [3:0]       qneg,
	output logic [3:0][31:0] quat
);

	typedef struct packed {
		logic [3:0][30:0] mg;
		logic [3:0]       neg;
		logic             zero;
	} nrm_tag_t;

	typedef struct packed {
		logic [3:0] neg;
		logic       zero;
	} nrm_out_t;

	logic [61:0]      mx_c, mx_s1;
	logic [3:0][61:0] mag_s1, mag_s2;
	logic [3:0]       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [5:0]       p_s2;
	logic             zero_s2, zero_s3, zero_s4, zero_s5;
	logic [61:0]      sh_c [4];
	logic [3:0][30:0] mg_s3, mg_s4, mg_s5;
	logic [3:0][61:0] sqr_s4;
	logic [63:0]      ss_s5;
	logic [31:0]      n_root;
	nrm_tag_t         tag_d [amtq_pkg::SQ_LAT];
	nrm_tag_t         tag_a;
	logic [32:0]      den_c;
	logic [3:0][61:0] num_c, quo;
	nrm_out_t         out_d [amtq_pkg::DIV_LAT];
	nrm_out_t         out_a;
	logic [30:0]      c_c [4];
	logic [3:0][31:0] quat_s4;

	// Largest magnitude.
	always_comb begin
		mx_c = qmag[0];
		for (int i = 1; i < 4; i++) begin
			if (qmag[i] > mx_c) begin
				mx_c = qmag[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= mx_c;
			mag_s1 <= qmag;
			neg_s1 <= qneg;
		end
	end

	// Leading bit of the largest magnitude sets the common shift.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= amtq_pkg::msb64({2'b00, mx_s1});
			zero_s2 <= (mx_s1 == 62'd0);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Bring the largest magnitude into [2^30, 2^31).
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (p_s2 > 6'd30) begin
				sh_c[i] = mag_s2[i] >> (p_s2 - 6'd30);
			end else begin
				sh_c[i] = mag_s2[i] << (6'd30 - p_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mg_s3[i] <= sh_c[i][30:0];
			end
			neg_s3 <= neg_s2;
			zero_s3 <= zero_s2;
		end
	end

	// Squares, then their sum.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sqr_s4[i] <= mg_s3[i] * mg_s3[i];
			end
			mg_s4 <= mg_s3;
			neg_s4 <= neg_s3;
			zero_s4 <= zero_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s5 <= {2'b00, sqr_s4[0]} + {2'b00, sqr_s4[1]} + {2'b00, sqr_s4[2]}
				+ {2'b00, sqr_s4[3]};
			mg_s5 <= mg_s4;
			neg_s5 <= neg_s4;
			zero_s5 <= zero_s4;
		end
	end

	amtq_sqrt u_sqrt (.clk(clk), .en(en), .rad(ss_s5), .root(n_root));

	always_ff @(posedge clk) begin
		if (en) begin
			tag_d[0] <= '{mg: mg_s5, neg: neg_s5, zero: zero_s5};
			for (int i = 1; i < amtq_pkg::SQ_LAT; i++) begin
				tag_d[i] <= tag_d[i-1];
			end
		end
	end

	assign tag_a = tag_d[amtq_pkg::SQ_LAT-1];

	// Each component over the norm, in Q30.
	always_comb begin
		den_c = (n_root == 32'd0) ? 33'd1 : {1'b0, n_root};
		for (int i = 0; i < 4; i++) begin
			num_c[i] = {1'b0, tag_a.mg[i], 30'b0};
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_div
		amtq_div u_div (.clk(clk), .en(en), .num(num_c[g]), .den(den_c), .quo(quo[g]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d[0] <= '{neg: tag_a.neg, zero: tag_a.zero};
			for (int i = 1; i < amtq_pkg::DIV_LAT; i++) begin
				out_d[i] <= out_d[i-1];
			end
		end
	end

	assign out_a = out_d[amtq_pkg::DIV_LAT-1];

	// Clamp, restore signs, or emit the identity for a zero quaternion.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			c_c[i] = (quo[i] > {31'b0, amtq_pkg::Q_ONE}) ? amtq_pkg::Q_ONE : quo[i][30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				if (out_a.zero) begin
					quat_s4[i] <= (i == 3) ? {1'b0, amtq_pkg::Q_ONE} : 32'd0;
				end else begin
					quat_s4[i] <= out_a.neg[i] ? 32'(-{1'b0, c_c[i]}) : {1'b0, c_c[i]};
				end
			end
		end
	end

	assign quat = quat_s4;

endmodule

// ===== rtl/amtq_checker.sv =====
// Port-level checks for the matrix decomposition block, bound to the top level.
module amtq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [319:0] m_axis_tdata
);

	// A stalled output beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// Input is taken exactly when the pipeline can advance.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow the output side");

	// Quaternion components stay within plus or minus one.
	a_quat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[127:96] <= 32'h4000_0000 || m_axis_tdata[127:96] >= 32'hC000_0000)
			&& (m_axis_tdata[159:128] <= 32'h4000_0000
				|| m_axis_tdata[159:128] >= 32'hC000_0000)
			&& (m_axis_tdata[191:160] <= 32'h4000_0000
				|| m_axis_tdata[191:160] >= 32'hC000_0000)
			&& (m_axis_tdata[223:192] <= 32'h4000_0000
				|| m_axis_tdata[223:192] >= 32'hC000_0000))
		else $error("quaternion component out of range");

	// A normalized quaternion is never all zero.
	a_quat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			m_axis_tdata[127:96] != 32'd0 || m_axis_tdata[159:128] != 32'd0
			|| m_axis_tdata[191:160] != 32'd0 || m_axis_tdata[223:192] != 32'd0)
		else $error("quaternion output is all zero");

endmodule

bind affine_matrix_to_trs_quaternion_unit amtq_checker u_amtq_checker (.*);
